@@ rtl/srw_pkg.sv @@
// ----------------------------------------------------------------------------
// srw_pkg
// Shared types and codes for the session replay window filter.
// ----------------------------------------------------------------------------
package srw_pkg;

    localparam int DEF_WINDOW_BITS   = 64;
    localparam int DEF_RETIRED_SLOTS = 8;

    localparam int CODE_W = 3;
    localparam int CNT_NUM = 6;
    localparam int CNT_IDX_W = 3;

    localparam logic [CODE_W-1:0] CODE_INVALID      = 3'd0;
    localparam logic [CODE_W-1:0] CODE_REJECTED     = 3'd1;
    localparam logic [CODE_W-1:0] CODE_DUPLICATE    = 3'd2;
    localparam logic [CODE_W-1:0] CODE_OUTSIDE      = 3'd3;
    localparam logic [CODE_W-1:0] CODE_EXHAUSTED    = 3'd4;
    localparam logic [CODE_W-1:0] CODE_NEW_SESSION  = 3'd5;
    localparam logic [CODE_W-1:0] CODE_IN_ORDER     = 3'd6;
    localparam logic [CODE_W-1:0] CODE_OUT_OF_ORDER = 3'd7;

    localparam logic [CNT_IDX_W-1:0] CNT_ACCEPTED   = 3'd0;
    localparam logic [CNT_IDX_W-1:0] CNT_DUPLICATES = 3'd1;
    localparam logic [CNT_IDX_W-1:0] CNT_REORDERED  = 3'd2;
    localparam logic [CNT_IDX_W-1:0] CNT_OUTSIDE    = 3'd3;
    localparam logic [CNT_IDX_W-1:0] CNT_REJECTED   = 3'd4;
    localparam logic [CNT_IDX_W-1:0] CNT_RESETS     = 3'd5;

    typedef struct packed {
        logic [31:0] session_ident;
        logic [31:0] seq_number;
    } t_srw_req;

    typedef struct packed {
        logic [CODE_W-1:0] delivery_code;
        logic              fresh_in_order;
        logic [31:0]       expected_next;
        logic [31:0]       window_low_bits;
        logic [31:0]       count_accepted;
        logic [31:0]       count_duplicates;
        logic [31:0]       count_reordered;
        logic [31:0]       count_outside;
        logic [31:0]       count_rejected;
        logic [31:0]       count_resets;
    } t_srw_rsp;

endpackage

@@ rtl/srw_if.sv @@
// ----------------------------------------------------------------------------
// srw_req_if / srw_rsp_if
// Valid/ready channels for requests into and results out of the filter.
// ----------------------------------------------------------------------------
interface srw_req_if;
    import srw_pkg::*;

    logic     valid;
    logic     ready;
    t_srw_req payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface srw_rsp_if;
    import srw_pkg::*;

    logic     valid;
    logic     ready;
    t_srw_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/session_replay_window.sv @@
// ----------------------------------------------------------------------------
// session_replay_window
// Anti-replay sliding window filter for one receiving session.
// Flow: check the request; on a switch, read and compare each retired id, then
//   retire the old id; test the window, count a reorder when it lands out of
//   order, slide over received bits, and hold the result until the output frees.
// Requests: one at a time; ready returns in the same cycle that the result is
//   registered. The retired-id scan and the one-bit-per-cycle slide set how long each takes.
// Reset: synchronous; clears session, window, ring pointers and counters.
// ----------------------------------------------------------------------------
module session_replay_window #(
    parameter int WINDOW_BITS   = srw_pkg::DEF_WINDOW_BITS,
    parameter int RETIRED_SLOTS = srw_pkg::DEF_RETIRED_SLOTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    srw_req_if.sink     i_req,
    srw_rsp_if.source   o_rsp
);
    import srw_pkg::*;

    localparam int BIT_W  = (WINDOW_BITS > 1) ? $clog2(WINDOW_BITS) : 1;
    localparam int IDX_W  = (RETIRED_SLOTS > 1) ? $clog2(RETIRED_SLOTS) : 1;
    localparam int FILL_W = $clog2(RETIRED_SLOTS + 1);
    localparam int LOW_W  = (WINDOW_BITS < 32) ? WINDOW_BITS : 32;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CHECK    = 4'd1;
    localparam logic [3:0] S_SCAN_RD  = 4'd2;
    localparam logic [3:0] S_SCAN_CMP = 4'd3;
    localparam logic [3:0] S_SWITCH   = 4'd4;
    localparam logic [3:0] S_WINDOW   = 4'd5;
    localparam logic [3:0] S_REORD    = 4'd6;
    localparam logic [3:0] S_SLIDE    = 4'd7;
    localparam logic [3:0] S_DONE     = 4'd8;

    logic [3:0]             r_state, n_state;
    logic                   r_present, n_present;
    logic [31:0]            r_cur, n_cur;
    logic [31:0]            r_next, n_next;
    logic [WINDOW_BITS-1:0] r_bitmap, n_bitmap;
    logic [IDX_W-1:0]       r_cursor, n_cursor;
    logic [FILL_W-1:0]      r_fill, n_fill;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic [31:0]            r_id, n_id;
    logic [31:0]            r_seq, n_seq;
    logic [CODE_W-1:0]      r_code, n_code;
    logic                   r_fresh, n_fresh;
    logic                   r_off_nz, n_off_nz;
    logic                   r_out_valid, n_out_valid;
    t_srw_rsp               r_rsp, n_rsp;
    logic [31:0]            r_cnt [CNT_NUM];

    logic [31:0]            r_mem [RETIRED_SLOTS];
    logic [31:0]            r_rd_data;
    logic                   mem_we;

    logic                   bump_en;
    logic [CNT_IDX_W-1:0]   bump_sel;

    logic [31:0]            offset;
    logic [BIT_W-1:0]       bit_idx;

    assign offset  = r_seq - r_next;
    assign bit_idx = offset[BIT_W-1:0];

    assign i_req.ready   = (r_state == S_IDLE);
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_rsp;

    always_comb begin
        n_state     = r_state;
        n_present   = r_present;
        n_cur       = r_cur;
        n_next      = r_next;
        n_bitmap    = r_bitmap;
        n_cursor    = r_cursor;
        n_fill      = r_fill;
        n_idx       = r_idx;
        n_id        = r_id;
        n_seq       = r_seq;
        n_code      = r_code;
        n_fresh     = r_fresh;
        n_off_nz    = r_off_nz;
        n_out_valid = r_out_valid & ~o_rsp.ready;
        n_rsp       = r_rsp;
        mem_we      = 1'b0;
        bump_en     = 1'b0;
        bump_sel    = CNT_ACCEPTED;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_id    = i_req.payload.session_ident;
                    n_seq   = i_req.payload.seq_number;
                    n_fresh = 1'b0;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_id == 32'd0 || r_seq == 32'd0) begin
                    n_code  = CODE_INVALID;
                    n_state = S_DONE;
                end else if (!r_present) begin
                    n_present = 1'b1;
                    n_cur     = r_id;
                    n_next    = 32'd1;
                    n_bitmap  = '0;
                    n_fresh   = 1'b1;
                    n_state   = S_WINDOW;
                end else if (r_cur != r_id) begin
                    if (r_seq != 32'd1) begin
                        bump_en  = 1'b1;
                        bump_sel = CNT_REJECTED;
                        n_code   = CODE_REJECTED;
                        n_state  = S_DONE;
                    end else if (r_fill == '0) begin
                        n_state = S_SWITCH;
                    end else begin
                        n_idx   = '0;
                        n_state = S_SCAN_RD;
                    end
                end else begin
                    n_state = S_WINDOW;
                end
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if (r_rd_data == r_id) begin
                    bump_en  = 1'b1;
                    bump_sel = CNT_REJECTED;
                    n_code   = CODE_REJECTED;
                    n_state  = S_DONE;
                end else if ((FILL_W'(r_idx) + FILL_W'(1)) == r_fill) begin
                    n_state = S_SWITCH;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = S_SCAN_RD;
                end
            end
            S_SWITCH: begin
                // retire the old id, then open the new session
                mem_we   = 1'b1;
                n_cursor = (r_cursor == IDX_W'(RETIRED_SLOTS - 1)) ?
                           '0 : r_cursor + IDX_W'(1);
                if (r_fill != FILL_W'(RETIRED_SLOTS)) begin
                    n_fill = r_fill + FILL_W'(1);
                end
                bump_en   = 1'b1;
                bump_sel  = CNT_RESETS;
                n_cur     = r_id;
                n_next    = 32'd1;
                n_bitmap  = '0;
                n_fresh   = 1'b1;
                n_state   = S_WINDOW;
            end
            S_WINDOW: begin
                if (r_seq < r_next) begin
                    bump_en  = 1'b1;
                    bump_sel = CNT_DUPLICATES;
                    n_code   = CODE_DUPLICATE;
                    n_state  = S_DONE;
                end else if (offset >= 32'(WINDOW_BITS)) begin
                    bump_en  = 1'b1;
                    bump_sel = CNT_OUTSIDE;
                    n_code   = CODE_OUTSIDE;
                    n_state  = S_DONE;
                end else if (r_bitmap[bit_idx]) begin
                    bump_en  = 1'b1;
                    bump_sel = CNT_DUPLICATES;
                    n_code   = CODE_DUPLICATE;
                    n_state  = S_DONE;
                end else begin
                    n_bitmap = r_bitmap | (WINDOW_BITS'(1) << bit_idx);
                    bump_en  = 1'b1;
                    bump_sel = CNT_ACCEPTED;
                    n_off_nz = (offset != 32'd0);
                    n_state  = (offset != 32'd0) ? S_REORD : S_SLIDE;
                end
            end
            S_REORD: begin
                bump_en  = 1'b1;
                bump_sel = CNT_REORDERED;
                n_state  = S_SLIDE;
            end
            S_SLIDE: begin
                // advance one received bit per cycle
                if (r_bitmap[0]) begin
                    n_bitmap = r_bitmap >> 1;
                    if (r_next == 32'hFFFF_FFFF) begin
                        n_code  = CODE_EXHAUSTED;
                        n_state = S_DONE;
                    end else begin
                        n_next = r_next + 32'd1;
                    end
                end else begin
                    if (r_off_nz) begin
                        n_code = CODE_OUT_OF_ORDER;
                    end else if (r_fresh) begin
                        n_code = CODE_NEW_SESSION;
                    end else begin
                        n_code = CODE_IN_ORDER;
                    end
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || o_rsp.ready) begin
                    n_rsp.delivery_code    = r_code;
                    n_rsp.fresh_in_order   = (r_code == CODE_NEW_SESSION) ||
                                             (r_code == CODE_IN_ORDER);
                    n_rsp.expected_next    = r_next;
                    n_rsp.window_low_bits  = 32'(r_bitmap[LOW_W-1:0]);
                    n_rsp.count_accepted   = r_cnt[CNT_ACCEPTED];
                    n_rsp.count_duplicates = r_cnt[CNT_DUPLICATES];
                    n_rsp.count_reordered  = r_cnt[CNT_REORDERED];
                    n_rsp.count_outside    = r_cnt[CNT_OUTSIDE];
                    n_rsp.count_rejected   = r_cnt[CNT_REJECTED];
                    n_rsp.count_resets     = r_cnt[CNT_RESETS];
                    n_out_valid            = 1'b1;
                    n_state                = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_present   <= 1'b0;
            r_cur       <= '0;
            r_next      <= 32'd1;
            r_bitmap    <= '0;
            r_cursor    <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_present   <= n_present;
            r_cur       <= n_cur;
            r_next      <= n_next;
            r_bitmap    <= n_bitmap;
            r_cursor    <= n_cursor;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_id     <= n_id;
        r_seq    <= n_seq;
        r_code   <= n_code;
        r_fresh  <= n_fresh;
        r_off_nz <= n_off_nz;
        r_rsp    <= n_rsp;
    end

    // shared counter incrementer, one event per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CNT_NUM; k++) begin
                r_cnt[k] <= '0;
            end
        end else if (bump_en) begin
            r_cnt[bump_sel] <= r_cnt[bump_sel] + 32'd1;
        end
    end

    // retired id ring
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_cursor] <= r_cur;
        end
        r_rd_data <= r_mem[r_idx];
    end

endmodule

@@ rtl/srw_checker.sv @@
// ----------------------------------------------------------------------------
// srw_checker
// Port-level checks for the session replay window, bound to the top level.
// ----------------------------------------------------------------------------
module srw_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_req_valid,
    input logic             i_req_ready,
    input logic             i_rsp_valid,
    input logic             i_rsp_ready,
    input srw_pkg::t_srw_rsp i_rsp_payload
);
    import srw_pkg::*;

    a_rsp_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("result dropped while stalled");

    a_rsp_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> $stable(i_rsp_payload))
        else $error("result changed while stalled");

    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("second request taken while one is in work");

    a_fresh_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> i_rsp_payload.fresh_in_order ==
            ((i_rsp_payload.delivery_code == CODE_NEW_SESSION) ||
             (i_rsp_payload.delivery_code == CODE_IN_ORDER)))
        else $error("fresh flag disagrees with delivery code");

    a_expected_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> i_rsp_payload.expected_next != 32'd0)
        else $error("expected sequence reported as zero");

endmodule

bind session_replay_window srw_checker u_srw_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_rsp_payload (o_rsp.payload)
);

@@ tb/sv/session_replay_window_tb.sv @@
// ----------------------------------------------------------------------------
// session_replay_window_tb
// Drives session id / sequence requests into the replay filter with random
// gaps on both channels. A scoreboard keeps its own copy of the session,
// window, retired-id ring and event counters, predicts each result and
// checks every field of every result in order.
// ----------------------------------------------------------------------------
module session_replay_window_tb;
    import srw_pkg::*;

    localparam int CLK_PERIOD   = 4;
    localparam int RANDOM_ITEMS = 1225;
    localparam int QUIET_TAIL   = 200;
    localparam int DRAIN_CYCLES = 100;
    localparam int LIMIT_CYCLES = 600_000;
    localparam int REPORT_MAX   = 10;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts the filter outcome for each accepted request.
    // ------------------------------------------------------------------------
    class replay_scoreboard;
        bit          open_session;
        logic [31:0] active_ident;
        logic [31:0] next_seq;
        logic [63:0] seen_map;
        logic [31:0] retired [DEF_RETIRED_SLOTS];
        int unsigned ring_pos;
        int unsigned ring_fill;
        logic [31:0] tally [CNT_NUM];
        t_srw_rsp    expected_q [$];
        int unsigned mismatches;
        int unsigned results_seen;
        int unsigned code_hits [8];

        function new();
            open_session = 1'b0;
            active_ident = '0;
            next_seq     = 32'd1;
            seen_map     = '0;
            ring_pos     = 0;
            ring_fill    = 0;
            mismatches   = 0;
            results_seen = 0;
            foreach (tally[k]) tally[k] = '0;
            foreach (code_hits[k]) code_hits[k] = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function logic [CODE_W-1:0] classify(logic [31:0] id, logic [31:0] seq);
            bit          fresh;
            bit          hit;
            logic [31:0] offset;
            logic [63:0] mask;

            fresh = 1'b0;
            if (id == '0 || seq == '0)
                return CODE_INVALID;
            if (!open_session) begin
                fresh = 1'b1;
            end else if (active_ident != id) begin
                hit = 1'b0;
                for (int unsigned k = 0; k < ring_fill; k++)
                    if (retired[k] == id) hit = 1'b1;
                if (seq != 32'd1 || hit) begin
                    tally[CNT_REJECTED]++;
                    return CODE_REJECTED;
                end
                retired[ring_pos] = active_ident;
                ring_pos = (ring_pos + 1) % DEF_RETIRED_SLOTS;
                if (ring_fill < DEF_RETIRED_SLOTS) ring_fill++;
                tally[CNT_RESETS]++;
                fresh = 1'b1;
            end
            if (fresh) begin
                open_session = 1'b1;
                active_ident = id;
                next_seq     = 32'd1;
                seen_map     = '0;
            end
            if (seq < next_seq) begin
                tally[CNT_DUPLICATES]++;
                return CODE_DUPLICATE;
            end
            offset = seq - next_seq;
            if (offset >= 32'(DEF_WINDOW_BITS)) begin
                tally[CNT_OUTSIDE]++;
                return CODE_OUTSIDE;
            end
            mask = 64'd1 << offset;
            if ((seen_map & mask) != '0) begin
                tally[CNT_DUPLICATES]++;
                return CODE_DUPLICATE;
            end
            seen_map |= mask;
            tally[CNT_ACCEPTED]++;
            if (offset != '0) tally[CNT_REORDERED]++;
            // slide over the leading run of received sequences
            while (seen_map[0]) begin
                seen_map = seen_map >> 1;
                if (next_seq == 32'hFFFF_FFFF)
                    return CODE_EXHAUSTED;
                next_seq++;
            end
            if (offset != '0)
                return CODE_OUT_OF_ORDER;
            return fresh ? CODE_NEW_SESSION : CODE_IN_ORDER;
        endfunction

        function void note_request(t_srw_req r);
            t_srw_rsp e;
            logic [CODE_W-1:0] code;

            code = classify(r.session_ident, r.seq_number);
            e.delivery_code    = code;
            e.fresh_in_order   = (code == CODE_NEW_SESSION || code == CODE_IN_ORDER);
            e.expected_next    = next_seq;
            e.window_low_bits  = seen_map[31:0];
            e.count_accepted   = tally[CNT_ACCEPTED];
            e.count_duplicates = tally[CNT_DUPLICATES];
            e.count_reordered  = tally[CNT_REORDERED];
            e.count_outside    = tally[CNT_OUTSIDE];
            e.count_rejected   = tally[CNT_REJECTED];
            e.count_resets     = tally[CNT_RESETS];
            expected_q.push_back(e);
        endfunction

        function void compare_field(string label, logic [31:0] want, logic [31:0] got_v);
            if (got_v !== want) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("mismatch on result %0d, %s: expected 0x%08h, got 0x%08h",
                             results_seen, label, want, got_v);
            end
        endfunction

        function void check_result(t_srw_rsp got);
            t_srw_rsp e;

            results_seen++;
            code_hits[got.delivery_code]++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result %0d with no request outstanding, code %0d",
                             results_seen, got.delivery_code);
                return;
            end
            e = expected_q.pop_front();
            compare_field("delivery_code", 32'(e.delivery_code), 32'(got.delivery_code));
            compare_field("fresh_in_order", 32'(e.fresh_in_order), 32'(got.fresh_in_order));
            compare_field("expected_next", e.expected_next, got.expected_next);
            compare_field("window_low_bits", e.window_low_bits, got.window_low_bits);
            compare_field("count_accepted", e.count_accepted, got.count_accepted);
            compare_field("count_duplicates", e.count_duplicates, got.count_duplicates);
            compare_field("count_reordered", e.count_reordered, got.count_reordered);
            compare_field("count_outside", e.count_outside, got.count_outside);
            compare_field("count_rejected", e.count_rejected, got.count_rejected);
            compare_field("count_resets", e.count_resets, got.count_resets);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels, block
    // ------------------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n;

    srw_req_if req_ch ();
    srw_rsp_if rsp_ch ();

    session_replay_window u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    replay_scoreboard sb = new();
    bit               idle_on;
    int unsigned      sent;
    int unsigned      directed_count;
    int unsigned      total_items;
    logic [31:0]      used_ids [$];

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    task automatic issue(input logic [31:0] id, input logic [31:0] seq);
        t_srw_req r;

        r.session_ident = id;
        r.seq_number    = seq;
        idle_on = (sent + QUIET_TAIL < total_items) && ((sent / 97) % 3 != 2);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= r;
        do @(posedge i_clk); while (!(req_ch.valid && req_ch.ready));
        sb.note_request(r);
        sent++;
    endtask

    function automatic logic [31:0] fresh_id();
        logic [31:0] id;

        id = $urandom;
        if (id == '0) id = 32'd1;
        used_ids.push_back(id);
        return id;
    endfunction

    task automatic run_directed();
        // bad id and bad sequence
        issue(32'h0000_0000, 32'hFFFF_FFFF);
        issue(32'h0000_0007, 32'h0000_0000);
        // first session opens even though the message lands outside the window
        issue(32'hFFFF_FFFF, 32'd70);
        issue(32'hFFFF_FFFF, 32'd1);
        issue(32'hFFFF_FFFF, 32'd3);
        issue(32'hFFFF_FFFF, 32'd3);
        issue(32'hFFFF_FFFF, 32'd2);
        issue(32'hFFFF_FFFF, 32'd1);
        // window edges: last slot in, first slot past it, top sequence
        issue(32'hFFFF_FFFF, 32'd67);
        issue(32'hFFFF_FFFF, 32'd68);
        issue(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // switch needs sequence 1, then the old id is retired
        issue(32'h1234_5678, 32'd2);
        issue(32'h1234_5678, 32'd1);
        issue(32'hFFFF_FFFF, 32'd1);
        issue(32'hA5A5_A5A5, 32'd1);
        // wrap the retired ring so the first retired id falls out of it
        for (int k = 0; k < 8; k++)
            issue(32'h0000_0100 + 32'(k), 32'd1);
        issue(32'hFFFF_FFFF, 32'd1);
        used_ids.push_back(32'hFFFF_FFFF);
        used_ids.push_back(32'h1234_5678);
        used_ids.push_back(32'hA5A5_A5A5);
        for (int k = 0; k < 8; k++)
            used_ids.push_back(32'h0000_0100 + 32'(k));
    endtask

    task automatic issue_random();
        int unsigned pick;
        logic [31:0] id;
        logic [31:0] seq;

        pick = $urandom_range(0, 99);
        id   = sb.active_ident;
        if (pick < 4) begin
            if ($urandom_range(0, 1) == 0) begin
                id  = '0;
                seq = $urandom;
            end else begin
                seq = '0;
            end
        end else if (pick < 9) begin
            id  = fresh_id();
            seq = 32'd1;
        end else if (pick < 12) begin
            id  = used_ids[$urandom_range(0, used_ids.size() - 1)];
            seq = 32'd1;
        end else if (pick < 15) begin
            id  = ($urandom_range(0, 1) == 0) ? used_ids[$urandom_range(0, used_ids.size() - 1)]
                                              : fresh_id();
            seq = $urandom_range(2, 300);
        end else if (pick < 19) begin
            seq = $urandom;
            if (seq == '0) seq = 32'd1;
        end else if (pick < 27) begin
            seq = (sb.next_seq > 32'd1) ? 32'($urandom_range(1, sb.next_seq - 1)) : 32'd1;
        end else if ($urandom_range(0, 3) == 0) begin
            seq = sb.next_seq;
        end else begin
            seq = sb.next_seq + 32'($urandom_range(0, 66));
        end
        issue(id, seq);
    endtask

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------
    initial begin
        rsp_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (idle_on && $urandom_range(0, 3) == 0) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_result(rsp_ch.payload);
    end

    // ------------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n        <= 1'b0;
        req_ch.valid   <= 1'b0;
        req_ch.payload <= '0;
        idle_on        = 1'b0;
        sent           = 0;
        directed_count = 24;
        total_items    = directed_count + RANDOM_ITEMS;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        repeat (RANDOM_ITEMS) issue_random();
        req_ch.valid <= 1'b0;
        idle_on = 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d requests (%0d directed), %0d results, %0d session ids tried",
                 sent, directed_count, sb.results_seen, used_ids.size());
        $display("codes: invalid %0d rejected %0d dup %0d outside %0d",
                 sb.code_hits[CODE_INVALID], sb.code_hits[CODE_REJECTED],
                 sb.code_hits[CODE_DUPLICATE], sb.code_hits[CODE_OUTSIDE]);
        $display("codes: exhausted %0d new %0d in-order %0d reordered %0d",
                 sb.code_hits[CODE_EXHAUSTED], sb.code_hits[CODE_NEW_SESSION],
                 sb.code_hits[CODE_IN_ORDER], sb.code_hits[CODE_OUT_OF_ORDER]);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("session_replay_window test passed");
        end else begin
            $display("%0d mismatches, %0d results outstanding", sb.mismatches, sb.pending());
            $display("session_replay_window test failed");
        end
        $finish;
    end

    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("timeout with %0d results outstanding", sb.pending());
        $display("session_replay_window test failed");
        $finish;
    end

endmodule
